// File: design/ncwp_pkg.sv
// ncwp_pkg: shared types, character codes and numeric limits of the nc coordinate word parser
// no dependencies
package ncwp_pkg;

    localparam int WORD_CHARS_DEF = 79;

    localparam int BYTE_W  = 8;
    localparam int ACC_W   = 40;          // holds the accumulator cap of 10^12
    localparam int MAG_W   = 30;          // holds 10^9
    localparam int VAL_W   = 31;          // signed micrometres
    localparam int SPEED_W = 16;

    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2e;
    localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_N     = 8'h4e;
    localparam logic [BYTE_W-1:0] CHAR_X     = 8'h58;
    localparam logic [BYTE_W-1:0] CHAR_Y     = 8'h59;
    localparam logic [BYTE_W-1:0] CHAR_Z     = 8'h5a;

    localparam logic [ACC_W-1:0] ACC_CAP = 40'd1000000000000;
    localparam logic [MAG_W-1:0] MAG_MAX = 30'd1000000000;

    // saturation limits on the accumulator for 0..3 fraction digits
    localparam logic [ACC_W-1:0] LIM_FRAC0 = 40'd1000000;
    localparam logic [ACC_W-1:0] LIM_FRAC1 = 40'd10000000;
    localparam logic [ACC_W-1:0] LIM_FRAC2 = 40'd100000000;
    localparam logic [ACC_W-1:0] LIM_FRAC3 = 40'd1000000000;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd1800;

    typedef enum logic [0:0] {
        CFG_DRILL  = 1'b0,
        CFG_TRAVEL = 1'b1
    } t_cfg_index;

    typedef enum logic [0:0] {
        EV_MOVE  = 1'b0,
        EV_SPEED = 1'b1
    } t_event_kind;

    typedef enum logic [4:0] {
        WS_IDLE = 5'b00001,
        WS_X    = 5'b00010,
        WS_Y    = 5'b00100,
        WS_Z    = 5'b01000,
        WS_N    = 5'b10000
    } t_word_state;

    // number word as it stands before the current byte
    typedef struct packed {
        logic              close;
        t_word_state       axis;
        logic              digit;
        logic              minus;
        logic [1:0]        frac;
        logic [ACC_W-1:0]  acc;
    } t_word_info;

endpackage

// File: design/nc_coordinate_word_parser.sv
// nc_coordinate_word_parser: top level of the nc text coordinate parser
// depends on ncwp_pkg, ncwp_word, ncwp_scale
//
// The block reads nc program text one byte per item and tracks X, Y and Z targets in
// micrometres. A letter X, Y, Z or N opens a number word of minus, digits and point; the
// first other byte closes it, and a closing X, Y or Z opens the next word straight away.
// The decimal value is converted exactly to micrometres (three fraction digits kept,
// truncated toward zero, saturating at +-1000000000). A word without a digit reuses the
// last parsed value; N values only update that value. A closing Z word at or above zero
// switches the feed to travel_speed, below zero to drill_speed, and reports the change
// once as a speed item. A LF directly after a CR reports a move item with the held
// targets and current feed; a LF that also closes a Z word reports only the move.
// Timing: one byte per cycle while no byte with a result waits on a full, stalled output.
// A byte is held in the input register, is parsed there by the word tracker and scaler,
// and its result (if any) lands in the output register, from which it is offered.
// The output register lets parsing continue while a result waits; only a byte that
// produces a result waits for a full output register to drain.
// Configuration writes are always ready and take effect at once; they should be made
// while no item is in flight.
module nc_coordinate_word_parser
    import ncwp_pkg::*;
#(
    parameter int WORD_CHARS = WORD_CHARS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // byte input
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [BYTE_W-1:0]         i_text_byte,
    // result output
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_event_kind,
    output logic signed [VAL_W-1:0]   o_target_x,
    output logic signed [VAL_W-1:0]   o_target_y,
    output logic signed [VAL_W-1:0]   o_target_z,
    output logic [SPEED_W-1:0]        o_feed_speed,
    // configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [0:0]                i_cfg_index,
    input  logic [SPEED_W-1:0]        i_cfg_data
);

    // input register
    logic                     r_in_valid;
    logic [BYTE_W-1:0]        r_in_byte;

    // configuration and held state
    logic [SPEED_W-1:0]       r_drill;
    logic [SPEED_W-1:0]       r_travel;
    logic [SPEED_W-1:0]       r_cur_speed;
    logic                     r_prev_cr;
    logic signed [VAL_W-1:0]  r_last;
    logic signed [VAL_W-1:0]  r_hold_x;
    logic signed [VAL_W-1:0]  r_hold_y;
    logic signed [VAL_W-1:0]  r_hold_z;

    // output register
    logic                     r_out_valid;
    t_event_kind              r_out_kind, n_out_kind;
    logic signed [VAL_W-1:0]  r_out_x, n_out_x;
    logic signed [VAL_W-1:0]  r_out_y, n_out_y;
    logic signed [VAL_W-1:0]  r_out_z, n_out_z;
    logic [SPEED_W-1:0]       r_out_feed, n_out_feed;

    t_word_info               w_info;
    logic signed [VAL_W-1:0]  w_scaled;
    logic signed [VAL_W-1:0]  w_value;
    logic                     w_advance;
    logic                     w_accept;
    logic                     w_move;
    logic                     w_speed_chg;
    logic                     w_has_result;
    logic [SPEED_W-1:0]       w_new_speed;
    logic                     w_cfg_write;

    ncwp_word #(
        .WORD_CHARS (WORD_CHARS)
    ) u_word (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_text_byte (r_in_byte),
        .o_info      (w_info)
    );

    ncwp_scale u_scale (
        .i_acc   (w_info.acc),
        .i_frac  (w_info.frac),
        .i_minus (w_info.minus),
        .o_value (w_scaled)
    );

    // word value: fresh conversion, or the last one when no digit came
    assign w_value = w_info.digit ? w_scaled : r_last;

    assign w_move      = (r_in_byte == CHAR_LF) && r_prev_cr;
    // z at or above zero wants travel speed, below zero leaves travel for drill
    assign w_speed_chg = w_info.close && (w_info.axis == WS_Z) &&
                         (w_value[VAL_W-1] ? (r_cur_speed == r_travel)
                                           : (r_cur_speed != r_travel));
    assign w_new_speed  = w_value[VAL_W-1] ? r_drill : r_travel;
    assign w_has_result = w_move || w_speed_chg;

    // a byte without a result never waits on the output side
    assign w_advance = r_in_valid && (!r_out_valid || !i_stall || !w_has_result);
    assign o_stall   = r_in_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if (w_move) begin
            // move carries the targets as held before this byte
            n_out_kind = EV_MOVE;
            n_out_x    = r_hold_x;
            n_out_y    = r_hold_y;
            n_out_z    = r_hold_z;
            n_out_feed = r_cur_speed;
        end else begin
            n_out_kind = EV_SPEED;
            n_out_x    = r_hold_x;
            n_out_y    = r_hold_y;
            n_out_z    = w_value;
            n_out_feed = w_new_speed;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_text_byte;
        end
    end

    // speed registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drill  <= SPEED_RESET;
            r_travel <= SPEED_RESET;
        end else if (w_cfg_write) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DRILL:  r_drill  <= i_cfg_data;
                CFG_TRAVEL: r_travel <= i_cfg_data;
                default:    r_drill  <= r_drill;
            endcase
        end
    end

    // held targets, last value and feed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cr   <= 1'b0;
            r_last      <= '0;
            r_hold_x    <= '0;
            r_hold_y    <= '0;
            r_hold_z    <= '0;
            r_cur_speed <= SPEED_RESET;
        end else if (w_advance) begin
            r_prev_cr <= (r_in_byte == CHAR_CR);
            if (w_info.close) begin
                if (w_info.digit) begin
                    r_last <= w_scaled;
                end
                case (w_info.axis)
                    WS_X:    r_hold_x <= w_value;
                    WS_Y:    r_hold_y <= w_value;
                    WS_Z:    r_hold_z <= w_value;
                    default: r_hold_x <= r_hold_x;
                endcase
                if (w_speed_chg) begin
                    r_cur_speed <= w_new_speed;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_result) begin
            r_out_kind <= n_out_kind;
            r_out_x    <= n_out_x;
            r_out_y    <= n_out_y;
            r_out_z    <= n_out_z;
            r_out_feed <= n_out_feed;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_target_x   = r_out_x;
    assign o_target_y   = r_out_y;
    assign o_target_z   = r_out_z;
    assign o_feed_speed = r_out_feed;

    // a pending speed item always matches the feed in force
    a_speed_feed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == EV_SPEED) |-> (r_out_feed == r_cur_speed))
        else $error("speed item feed differs from current feed");

    // converted X and Z targets stay inside the saturation range
    a_target_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_z <= $signed({1'b0, MAG_MAX}) &&
                         r_out_z >= -$signed({1'b0, MAG_MAX}) &&
                         r_out_x <= $signed({1'b0, MAG_MAX}) &&
                         r_out_x >= -$signed({1'b0, MAG_MAX})))
        else $error("target outside saturation range");

    // a new result only comes from a byte held in the input register
    a_result_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_has_result) |=> (r_out_valid && $past(r_in_valid)))
        else $error("result register loaded without a byte");

endmodule

// File: design/ncwp_word.sv
// ncwp_word: number word tracker, letter decode and decimal accumulator
// depends on ncwp_pkg
module ncwp_word
    import ncwp_pkg::*;
#(
    parameter int WORD_CHARS = WORD_CHARS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_text_byte,
    output t_word_info        o_info
);

    localparam int CNT_W = $clog2(WORD_CHARS + 1);

    t_word_state        r_state, n_state;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic               r_minus, n_minus;
    logic               r_point, n_point;
    logic [1:0]         r_frac, n_frac;
    logic               r_digit, n_digit;
    logic               r_stop, n_stop;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic               w_is_digit;
    logic               w_is_num;
    logic [ACC_W+3:0]   w_acc10;

    function automatic t_word_state letter_state(input logic [BYTE_W-1:0] c,
                                                 input logic allow_n);
        t_word_state s;
        s = WS_IDLE;
        if (c == CHAR_X) begin
            s = WS_X;
        end else if (c == CHAR_Y) begin
            s = WS_Y;
        end else if (c == CHAR_Z) begin
            s = WS_Z;
        end else if (c == CHAR_N && allow_n) begin
            s = WS_N;
        end
        return s;
    endfunction

    assign w_is_digit = i_text_byte inside {[CHAR_0:CHAR_9]};
    assign w_is_num   = w_is_digit || (i_text_byte == CHAR_MINUS) || (i_text_byte == CHAR_POINT);
    // acc * 10 + digit, digit is the low nibble of an ascii digit
    assign w_acc10 = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + {(ACC_W)'(0), i_text_byte[3:0]};

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_minus = r_minus;
        n_point = r_point;
        n_frac  = r_frac;
        n_digit = r_digit;
        n_stop  = r_stop;
        n_cnt   = r_cnt;
        if (r_state == WS_IDLE || !w_is_num) begin
            // open a new word, or go idle
            n_state = letter_state(i_text_byte, r_state == WS_IDLE);
            n_acc   = '0;
            n_minus = 1'b0;
            n_point = 1'b0;
            n_frac  = '0;
            n_digit = 1'b0;
            n_stop  = 1'b0;
            n_cnt   = '0;
        end else if (r_cnt >= CNT_W'(WORD_CHARS)) begin
            n_stop = 1'b1;
        end else begin
            n_cnt = r_cnt + 1'b1;
            if (!r_stop) begin
                if (i_text_byte == CHAR_MINUS) begin
                    if (r_cnt == '0) begin
                        n_minus = 1'b1;
                    end else begin
                        n_stop = 1'b1;
                    end
                end else if (i_text_byte == CHAR_POINT) begin
                    if (r_point) begin
                        n_stop = 1'b1;
                    end else begin
                        n_point = 1'b1;
                    end
                end else begin
                    n_digit = 1'b1;
                    if (!(r_point && r_frac == 2'd3)) begin
                        if (r_point) begin
                            n_frac = r_frac + 1'b1;
                        end
                        if (w_acc10 > {4'b0000, ACC_CAP}) begin
                            n_acc = ACC_CAP;
                        end else begin
                            n_acc = w_acc10[ACC_W-1:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= WS_IDLE;
            r_acc   <= '0;
            r_minus <= 1'b0;
            r_point <= 1'b0;
            r_frac  <= '0;
            r_digit <= 1'b0;
            r_stop  <= 1'b0;
            r_cnt   <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_minus <= n_minus;
            r_point <= n_point;
            r_frac  <= n_frac;
            r_digit <= n_digit;
            r_stop  <= n_stop;
            r_cnt   <= n_cnt;
        end
    end

    assign o_info.close = (r_state != WS_IDLE) && !w_is_num;
    assign o_info.axis  = r_state;
    assign o_info.digit = r_digit;
    assign o_info.minus = r_minus;
    assign o_info.frac  = r_frac;
    assign o_info.acc   = r_acc;

endmodule

// File: design/ncwp_scale.sv
// ncwp_scale: turns an accumulated decimal word into signed micrometres with saturation
// depends on ncwp_pkg
module ncwp_scale
    import ncwp_pkg::*;
(
    input  logic [ACC_W-1:0]        i_acc,
    input  logic [1:0]              i_frac,
    input  logic                    i_minus,
    output logic signed [VAL_W-1:0] o_value
);

    logic [ACC_W-1:0] w_lim;
    logic [ACC_W-1:0] w_low;
    logic [ACC_W-1:0] w_prod;
    logic [MAG_W-1:0] w_mag;
    logic             w_sat;

    // low bits only matter when the value is below the limit
    assign w_low = {(ACC_W-MAG_W)'(0), i_acc[MAG_W-1:0]};

    always_comb begin
        case (i_frac)
            2'd0: begin
                w_lim  = LIM_FRAC0;
                w_prod = (w_low << 10) - (w_low << 4) - (w_low << 3);   // x1000
            end
            2'd1: begin
                w_lim  = LIM_FRAC1;
                w_prod = (w_low << 6) + (w_low << 5) + (w_low << 2);    // x100
            end
            2'd2: begin
                w_lim  = LIM_FRAC2;
                w_prod = (w_low << 3) + (w_low << 1);                   // x10
            end
            default: begin
                w_lim  = LIM_FRAC3;
                w_prod = w_low;
            end
        endcase
    end

    assign w_sat   = i_acc > w_lim;
    assign w_mag   = w_sat ? MAG_MAX : w_prod[MAG_W-1:0];
    assign o_value = i_minus ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});

endmodule
